// ===== src/scaled_pixel_run_length_encoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scaled pixel run-length encoder
// Clocked implication checks, reset-qualified, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef SCALED_PIXEL_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH
`define SCALED_PIXEL_RUN_LENGTH_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define SPRE_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPRE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spre_pkg.sv =====
// ----------------------------------------------------------------------------
// spre_pkg
// Shared types and constants of the scaled pixel run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package spre_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned ScaleW    = 5;
  localparam int unsigned RunCap    = 255;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [ScaleW-1:0] ScaleReset  = ScaleW'(1);
  localparam logic [PixW-1:0]   OffsetReset = '0;

  typedef enum logic [AddrW-1:0] {
    REG_SCALE_FACTOR = 3'd0,
    REG_COLOR_OFFSET = 3'd4
  } reg_addr_t;

  typedef struct packed {
    logic [ScaleW-1:0] scale_factor;
    logic [PixW-1:0]   color_offset;
  } cfg_t;

  typedef struct packed {
    logic            frame_last;
    logic [PixW-1:0] run_value;
    logic [PixW-1:0] run_length;
  } pair_t;

  typedef struct packed {
    logic [1:0] count;
    pair_t      p0;
    pair_t      p1;
  } push_t;

endpackage

`default_nettype wire

// ===== src/spre_cfg.sv =====
// ----------------------------------------------------------------------------
// spre_cfg
// Register file for scale factor and color offset behind the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module spre_cfg
  import spre_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_factor <= ScaleReset;
      cfg.color_offset <= OffsetReset;
    end else if (wr_en) begin
      if (paddr[2] == REG_COLOR_OFFSET[2]) begin
        cfg.color_offset <= pwdata[PixW-1:0];
      end else begin
        cfg.scale_factor <= pwdata[ScaleW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_COLOR_OFFSET[2]) begin
      prdata = DataW'(cfg.color_offset);
    end else begin
      prdata = DataW'(cfg.scale_factor);
    end
  end

endmodule

`default_nettype wire

// ===== src/spre_core.sv =====
// ----------------------------------------------------------------------------
// spre_core
// Input register, open-run state and one-pass run update per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module spre_core
  import spre_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cfg_t            cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [PixW-1:0] in_cell,
  input  wire logic            in_end,
  input  wire logic            room,
  output push_t                push
);

  logic            held;
  logic [PixW-1:0] cell_q;
  logic            end_q;
  logic [PixW-1:0] open_value;
  logic [PixW-1:0] open_length;
  logic [PixW-1:0] open_value_next;
  logic [PixW-1:0] open_length_next;

  logic            fire;
  logic [PixW-1:0] pixel;
  logic [PixW-1:0] reps;
  logic [PixW:0]   total;
  logic            match;
  logic            first_v;
  pair_t           first_p;
  pair_t           last_p;
  logic [PixW-1:0] run_value_upd;
  logic [PixW-1:0] run_length_upd;

  assign fire     = held && room;
  assign in_ready = !held || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cell_q <= in_cell;
      end_q  <= in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_value  <= '0;
      open_length <= '0;
    end else if (fire) begin
      open_value  <= open_value_next;
      open_length <= open_length_next;
    end
  end

  always_comb begin
    pixel = cell_q + cfg.color_offset;
    reps  = (cfg.scale_factor == '0) ? PixW'(1) : PixW'(cfg.scale_factor);
    total = {1'b0, open_length} + {1'b0, reps};
    match = (open_length != '0) && (pixel == open_value);

    first_v = 1'b0;
    first_p = '{frame_last: 1'b0, run_value: open_value, run_length: open_length};
    run_value_upd  = open_value;
    run_length_upd = total[PixW-1:0];

    if (match) begin
      if (total > (PixW+1)'(RunCap)) begin
        first_v            = 1'b1;
        first_p.run_length = PixW'(RunCap);
        run_length_upd     = PixW'(total - (PixW+1)'(RunCap));
      end
    end else begin
      first_v        = (open_length != '0);
      run_value_upd  = pixel;
      run_length_upd = reps;
    end

    last_p = '{frame_last: 1'b1, run_value: run_value_upd, run_length: run_length_upd};

    if (end_q) begin
      open_value_next  = '0;
      open_length_next = '0;
    end else begin
      open_value_next  = run_value_upd;
      open_length_next = run_length_upd;
    end

    push.p0    = first_v ? first_p : last_p;
    push.p1    = last_p;
    push.count = fire ? ({1'b0, first_v} + {1'b0, end_q}) : 2'd0;
  end

endmodule

`default_nettype wire

// ===== src/spre_fifo.sv =====
// ----------------------------------------------------------------------------
// spre_fifo
// Small result queue taking up to two pairs per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scaled_pixel_run_length_encoder_unit_assert.svh"

module spre_fifo
  import spre_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output pair_t      out_pair
);

  localparam int unsigned CntW = FifoPtrW + 1;

  pair_t               slots [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [CntW-1:0]     count;
  logic [CntW-1:0]     count_next;
  logic                pop;
  logic [FifoPtrW-1:0] wr_ptr_b;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_pair  = slots[rd_ptr];
  assign room      = (count <= CntW'(FifoDepth - 2));
  assign wr_ptr_b  = wr_ptr + FifoPtrW'(1);

  always_comb begin
    count_next = count + CntW'(push.count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FifoPtrW'(push.count);
      rd_ptr <= rd_ptr + FifoPtrW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.p0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr_b] <= push.p1;
    end
  end

  `SPRE_ASSERT_NOW(a_no_overflow, clk, rst, 1'b1, count <= CntW'(FifoDepth), "queue overflow")
  `SPRE_ASSERT_NOW(a_push_has_room, clk, rst, push.count != 2'd0, room, "push without room")
  `SPRE_ASSERT_NOW(a_pair_nonzero, clk, rst, push.count != 2'd0, push.p0.run_length != '0,
                   "empty run pushed")
  `SPRE_ASSERT_NEXT(a_pop_drains, clk, rst, pop && push.count == 2'd0,
                    count == $past(count) - CntW'(1), "pop did not drain")

endmodule

`default_nettype wire

// ===== src/scaled_pixel_run_length_encoder_unit.sv =====
// Scaled pixel run-length encoder.
// Input stream: one source cell per transfer, s_tdata = cell_value, s_tlast
// marks the final cell of a frame. Each cell gets color_offset added modulo
// 256 and is repeated scale_factor times horizontally (0 counts as 1).
// Output stream: (run_length, run_value) pairs, m_tlast on the frame's final
// pair. Runs longer than 255 are split into 255 and the remainder.
// Registers over APB: scale_factor at 0x0, color_offset at 0x4; write only
// while the stream is idle.
// Flow: a cell is registered on acceptance, and any pairs it completes are
// written to a four-entry result queue once the queue has room; m_tvalid is
// driven by that queue. Throughput: one cell per cycle while the queue has
// room; the result port delivers one pair per cycle while m_tready is high,
// so cells producing two pairs occupy the output port for two transfers.
// A receiver stall fills the queue; s_tready drops once fewer than two
// queue entries are free and the input register is occupied.
// Reset clears the open run, the queue and the registers (scale 1, offset 0).
`default_nettype none

// ----------------------------------------------------------------------------
// scaled_pixel_run_length_encoder_unit
// Top level: config registers, run update core and result queue.
// ----------------------------------------------------------------------------
module scaled_pixel_run_length_encoder_unit
  import spre_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] cell_value
  input  wire logic             s_tlast,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [15:0]      m_tdata,   // [7:0] run_length, [15:8] run_value
  output logic                  m_tlast,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg;
  push_t push;
  logic  room;
  pair_t out_pair;

  spre_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spre_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cell  (s_tdata),
    .in_end   (s_tlast),
    .room     (room),
    .push     (push)
  );

  spre_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pair  (out_pair)
  );

  assign m_tdata = {out_pair.run_value, out_pair.run_length};
  assign m_tlast = out_pair.frame_last;

endmodule

`default_nettype wire
